// ===== design/swrc_pkg.sv =====
// ----------------------------------------------------------------------------
// swrc_pkg
// Shared types and constants for the sliding-window rate counter table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrc_pkg;

  // table geometry
  localparam int NUM_COUNTERS = 256;
  localparam int WINDOW       = 5;

  // field widths
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int ACT_W   = 9;
  localparam int ADDR_W  = $clog2(NUM_COUNTERS);

  // bucket walk for the read sum
  localparam int BKT_IDX_W = $clog2(WINDOW);
  localparam int SUM_CNT_W = $clog2(WINDOW + 1);

  // divide-by-window unit: bits retired per cycle
  localparam int DIV_BITS_PER_STEP = 8;
  localparam int DIV_STEPS         = DATA_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);
  localparam int REM_W             = $clog2(WINDOW);

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_COLLECT = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_TICK,
    ST_RD_SUM,
    ST_RD_DIV
  } state_e;

  // one memory row: running total above the window buckets
  typedef struct packed {
    logic [DATA_W-1:0]             total;
    logic [WINDOW-1:0][DATA_W-1:0] bkt;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/swrc_ram.sv =====
// ----------------------------------------------------------------------------
// swrc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/swrc_div.sv =====
// ----------------------------------------------------------------------------
// swrc_div
// Signed divide by WINDOW, truncating toward zero. Sign-magnitude long
// division, DIV_BITS_PER_STEP quotient bits per cycle, then a sign fix-up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swrc_pkg::div_req_t req_i,
  output swrc_pkg::div_rsp_t     rsp_o
);

  import swrc_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [DATA_W-1:0]    mag_q, mag_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DATA_W-1:0]    quot_q;

  // one group of restoring steps on the narrow remainder
  always_comb begin
    logic [REM_W:0] r;
    logic           q;
    mag_d = mag_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      r     = {rem_d, mag_d[DATA_W-1]};
      q     = (r >= (REM_W+1)'(WINDOW));
      rem_d = q ? REM_W'(r - (REM_W+1)'(WINDOW)) : REM_W'(r);
      mag_d = {mag_d[DATA_W-2:0], q};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DATA_W-1];
      mag_q <= req_i.dividend[DATA_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
        quot_q <= neg_q ? (~mag_q + 1'b1) : mag_q;
      end else begin
        mag_q <= mag_d;
        rem_q <= rem_d;
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quot_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_rate_counters.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_counters
// Table of counters, each with WINDOW buckets and a running total, in one RAM.
// Input channel (in_valid_i/in_ready_o): func, counter_index, add_value.
// Output channel (out_valid_o/out_ready_i): one result per read transaction.
// cfg_we_i writes active_count; write only while the block is idle.
// Steps per transaction, set by the RAM ports and the divide unit:
//   clear writes a zero row on acceptance, collect reads, then writes back,
//   tick walks n = min(active_count, NUM_COUNTERS) rows, one row a cycle,
//   reading each row and writing back the aged row read before it,
//   read accepts and reads the row, sums its buckets, runs the divider,
//   then loads the output register.
// Reset clears every counter at once through per-row valid bits, and
// active_count to zero. A stalled receiver holds one result in the output
// register; later transactions are still taken, and a further read waits
// at its end until that register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_rate_counters (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swrc_pkg::ACT_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [swrc_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [swrc_pkg::IDX_W-1:0]    counter_index_i,
  input  wire logic signed [swrc_pkg::DATA_W-1:0] add_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [swrc_pkg::DATA_W-1:0] window_average_o,
  output logic signed [swrc_pkg::DATA_W-1:0] running_total_o,
  output logic      [swrc_pkg::IDX_W-1:0]    echo_index_o
);

  import swrc_pkg::*;

  state_e state_q, state_d;

  logic [ACT_W-1:0]     active_q;
  logic [ACT_W-1:0]     tick_n;
  logic [ACT_W-1:0]     rd_cnt_q;
  logic                 wr_vld_q;
  logic [ADDR_W-1:0]    wr_addr_q;
  logic [SUM_CNT_W-1:0] sum_cnt_q;
  logic [DATA_W-1:0]    sum_q;
  logic [DATA_W-1:0]    total_q;
  logic [ADDR_W-1:0]    idx_q;
  logic [DATA_W-1:0]    add_q;
  logic [NUM_COUNTERS-1:0] row_vld_q;
  logic                 vld_rd_q;

  logic                 in_acc;
  logic                 tick_rd;
  logic                 out_load;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    avg_q;
  logic [DATA_W-1:0]    tot_out_q;
  logic [IDX_W-1:0]     echo_q;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  row_t                 ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  row_t                 row_rd, row_col, row_age;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // tick walk length, clamped to the table size
  assign tick_n  = (active_q > ACT_W'(NUM_COUNTERS)) ? ACT_W'(NUM_COUNTERS) : active_q;
  assign tick_rd = (state_q == ST_TICK) && (rd_cnt_q < tick_n);

  // row as seen by the logic: never-written rows read as zero
  assign row_rd = vld_rd_q ? row_t'(ram_rdata) : '0;

  // collect: add into the current bucket and the total
  always_comb begin
    row_col          = row_rd;
    row_col.bkt[0]   = row_rd.bkt[0] + add_q;
    row_col.total    = row_rd.total + add_q;
  end

  // tick: every bucket one place older, current bucket cleared
  always_comb begin
    row_age        = row_rd;
    row_age.bkt[0] = '0;
    for (int j = 1; j < WINDOW; j++) begin
      row_age.bkt[j] = row_rd.bkt[j-1];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_e'(func_i))
            FUNC_COLLECT: state_d = ST_COLLECT;
            FUNC_TICK:    state_d = ST_TICK;
            FUNC_READ:    state_d = ST_RD_SUM;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_COLLECT: state_d = ST_IDLE;
      ST_TICK: begin
        if (!tick_rd && !wr_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_SUM: begin
        if (sum_cnt_q == SUM_CNT_W'(WINDOW)) begin
          state_d = ST_RD_DIV;
        end
      end
      ST_RD_DIV: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port, divider start and result load
  always_comb begin
    ram_re           = 1'b0;
    ram_raddr        = counter_index_i;
    ram_we           = 1'b0;
    ram_waddr        = idx_q;
    ram_wdata        = row_col;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    out_load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_COLLECT || func_i == FUNC_READ) begin
            ram_re = 1'b1;
          end
          if (func_i == FUNC_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = counter_index_i;
            ram_wdata = '0;
          end
        end
      end
      ST_COLLECT: begin
        ram_we = 1'b1;
      end
      ST_TICK: begin
        ram_re    = tick_rd;
        ram_raddr = rd_cnt_q[ADDR_W-1:0];
        ram_we    = wr_vld_q;
        ram_waddr = wr_addr_q;
        ram_wdata = row_age;
      end
      ST_RD_SUM: begin
        div_req.start = (sum_cnt_q == SUM_CNT_W'(WINDOW));
      end
      ST_RD_DIV: begin
        out_load = !div_rsp.busy && (!out_valid_q || out_ready_i);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      row_vld_q   <= '0;
      rd_cnt_q    <= '0;
      wr_vld_q    <= 1'b0;
      sum_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        row_vld_q[ram_waddr] <= 1'b1;
      end
      if (state_q == ST_TICK) begin
        wr_vld_q <= tick_rd;
        if (tick_rd) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
      end else begin
        wr_vld_q <= 1'b0;
        rd_cnt_q <= '0;
      end
      if (state_q == ST_RD_SUM) begin
        sum_cnt_q <= sum_cnt_q + 1'b1;
      end else begin
        sum_cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q <= counter_index_i;
      add_q <= add_value_i;
    end
    if (ram_re) begin
      vld_rd_q <= row_vld_q[ram_raddr];
    end
    if (tick_rd) begin
      wr_addr_q <= rd_cnt_q[ADDR_W-1:0];
    end
    // bucket sum, one bucket a cycle
    if (state_q == ST_RD_SUM && sum_cnt_q != SUM_CNT_W'(WINDOW)) begin
      if (sum_cnt_q == '0) begin
        sum_q   <= row_rd.bkt[0];
        total_q <= row_rd.total;
      end else begin
        sum_q <= sum_q + row_rd.bkt[sum_cnt_q[BKT_IDX_W-1:0]];
      end
    end
    if (out_load) begin
      avg_q     <= div_rsp.quotient;
      tot_out_q <= total_q;
      echo_q    <= IDX_W'(idx_q);
    end
  end

  // counter store
  swrc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_COUNTERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divide by the window length
  swrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign window_average_o = avg_q;
  assign running_total_o  = tot_out_q;
  assign echo_index_o     = echo_q;

endmodule

`default_nettype wire

// ===== design/swrc_checker.sv =====
// ----------------------------------------------------------------------------
// swrc_checker
// Port-level checks on the counter table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [swrc_pkg::FUNC_W-1:0]   func_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [swrc_pkg::DATA_W-1:0] window_average_o,
  input wire logic signed [swrc_pkg::DATA_W-1:0] running_total_o,
  input wire logic [swrc_pkg::IDX_W-1:0]    echo_index_o
);

  import swrc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(window_average_o) && $stable(running_total_o) && $stable(echo_index_o))
    else $error("result payload changed while stalled");

  // every transaction but a clear drops in_ready_o in the cycle after it is accepted
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i != FUNC_CLEAR |=> !in_ready_o)
    else $error("input taken back to back after a multi-cycle operation");

  // a result never appears straight after an input transaction
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared one cycle after an input transaction");

endmodule

bind sliding_window_rate_counters swrc_checker u_swrc_checker (.*);

`default_nettype wire

// ===== sim/sliding_window_rate_counters_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_counters_tb
// Self-checking bench for the sliding-window rate counter table.
// A valid/ready driver sends collect, tick, read and clear transactions. The
// bench keeps its own copy of the bucket and total store and checks every
// read result field by field. The run goes through several active_count
// settings, including the extremes, and several traffic patterns: no idling,
// long sender gaps, heavy receiver back-pressure, and both at once.
// ----------------------------------------------------------------------------
module sliding_window_rate_counters_tb;
  import swrc_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  // longest tick walk plus margin, for the pause before a register write
  localparam int SETTLE_CYCLES  = NUM_COUNTERS + 40;
  localparam int WATCHDOG_MAX   = 20000;
  localparam int RAND_PER_PHASE = 112;
  localparam int NUM_PHASES     = 6;
  localparam int MAX_REPORTS    = 10;

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    func_e             func;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } txn_t;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] total;
    logic [IDX_W-1:0]  idx;
  } read_result_t;

  // dut connections
  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [ACT_W-1:0]         cfg_wdata = '0;
  logic                     in_valid  = 1'b0;
  func_e                    in_func   = FUNC_COLLECT;
  logic [IDX_W-1:0]         in_index  = '0;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [DATA_W-1:0] window_average;
  logic signed [DATA_W-1:0] running_total;
  logic [IDX_W-1:0]         echo_index;

  // shadow copy of the counter store
  logic [DATA_W-1:0] bucket_store [NUM_COUNTERS][WINDOW];
  logic [DATA_W-1:0] total_store  [NUM_COUNTERS];
  logic [ACT_W-1:0]  active_count_shadow;

  txn_t         pending_txns [$];
  read_result_t expected_reads [$];
  txn_t         drive_txn;
  read_result_t want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int func_counts [4];
  int reads_checked  = 0;
  int check_failures = 0;
  int stall_cycles   = 0;

  sliding_window_rate_counters u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (in_func),
    .counter_index_i  (in_index),
    .add_value_i      (in_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .window_average_o (window_average),
    .running_total_o  (running_total),
    .echo_index_o     (echo_index)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // apply one accepted transaction to the shadow store, queue any read result
  function automatic void update_counter_table(txn_t t);
    int unsigned       n_aged;
    logic [DATA_W-1:0] bucket_sum;
    read_result_t      r;
    bit                in_range;
    in_range = int'(t.idx) < NUM_COUNTERS;
    case (t.func)
      FUNC_COLLECT: begin
        if (in_range) begin
          bucket_store[t.idx][0] = bucket_store[t.idx][0] + t.value;
          total_store[t.idx]     = total_store[t.idx] + t.value;
        end
      end
      FUNC_TICK: begin
        n_aged = (active_count_shadow > NUM_COUNTERS) ? NUM_COUNTERS : active_count_shadow;
        for (int c = 0; c < n_aged; c++) begin
          for (int j = WINDOW - 1; j > 0; j--) bucket_store[c][j] = bucket_store[c][j-1];
          bucket_store[c][0] = '0;
        end
      end
      FUNC_CLEAR: begin
        if (in_range) begin
          for (int j = 0; j < WINDOW; j++) bucket_store[t.idx][j] = '0;
          total_store[t.idx] = '0;
        end
      end
      default: begin
        r.average = '0;
        r.total   = '0;
        r.idx     = t.idx;
        if (in_range) begin
          bucket_sum = '0;
          for (int j = 0; j < WINDOW; j++) bucket_sum = bucket_sum + bucket_store[t.idx][j];
          // signed division truncates toward zero
          r.average = $signed(bucket_sum) / $signed(DATA_W'(WINDOW));
          r.total   = total_store[t.idx];
        end
        expected_reads.push_back(r);
      end
    endcase
  endfunction

  // random transaction, biased towards a few hot counters so state builds up
  function automatic txn_t random_txn();
    txn_t        t;
    int unsigned pick;
    int unsigned span;
    int          small_val;
    pick = $urandom_range(99);
    if (pick < 48)      t.func = FUNC_COLLECT;
    else if (pick < 80) t.func = FUNC_READ;
    else if (pick < 95) t.func = FUNC_TICK;
    else                t.func = FUNC_CLEAR;
    span = (active_count_shadow > NUM_COUNTERS) ? NUM_COUNTERS : active_count_shadow;
    pick = $urandom_range(9);
    if (pick < 5)                  t.idx = IDX_W'($urandom_range(7));
    else if (pick < 7)             t.idx = IDX_W'($urandom_range(255, 250));
    else if (pick < 8 && span > 0) t.idx = IDX_W'($urandom_range(span - 1));
    else                           t.idx = IDX_W'($urandom);
    pick = $urandom_range(9);
    small_val = (pick == 9) ? int'($urandom_range(2)) - 1 : int'($urandom_range(2000)) - 1000;
    case (pick)
      4, 5, 6: t.value = {$urandom, $urandom};
      7:       t.value = MAX_POS;
      8:       t.value = MIN_NEG;
      default: t.value = {{(DATA_W-32){small_val[31]}}, small_val};
    endcase
    return t;
  endfunction

  task automatic queue_txn(input func_e f, input int idx, input logic [DATA_W-1:0] v);
    txn_t t;
    t.func  = f;
    t.idx   = IDX_W'(idx);
    t.value = v;
    pending_txns.push_back(t);
  endtask

  // wait until every transaction is sent and every read result has come back
  task automatic wait_for_drain(input int extra_cycles);
    do @(negedge clk_i);
    while (pending_txns.size() != 0 || in_valid || expected_reads.size() != 0);
    repeat (extra_cycles) @(negedge clk_i);
  endtask

  task automatic write_active_count(input logic [ACT_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    active_count_shadow = value;
    @(negedge clk_i);
  endtask

  // driver: predicts on acceptance, then offers the next pending transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_counter_table('{in_func, in_index, in_value});
        func_counts[in_func]++;
      end
      if (!in_valid || in_ready) begin
        if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_txn = pending_txns.pop_front();
          in_valid <= 1'b1;
          in_func  <= drive_txn.func;
          in_index <= drive_txn.idx;
          in_value <= drive_txn.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each read result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reads.size() == 0) begin
          if (check_failures < MAX_REPORTS)
            $display("unexpected read result for counter %0d", echo_index);
          check_failures++;
        end else begin
          want = expected_reads.pop_front();
          reads_checked++;
          if (window_average !== want.average || running_total !== want.total ||
              echo_index !== want.idx) begin
            if (check_failures < MAX_REPORTS) begin
              $display("read mismatch: expected avg %0d total %0d index %0d",
                       $signed(want.average), $signed(want.total), want.idx);
              $display("               actual   avg %0d total %0d index %0d",
                       window_average, running_total, echo_index);
            end
            check_failures++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned phase_cfg  [NUM_PHASES];
    int          phase_send [NUM_PHASES];
    int          phase_recv [NUM_PHASES];
    phase_cfg  = '{256, 511, 0, 1, 2, 255};
    phase_send = '{0, 86, 0, 30, 0, 30};
    phase_recv = '{0, 0, 86, 30, 0, 30};
    phase_cfg[4] = $urandom_range(254, 2);
    for (int c = 0; c < NUM_COUNTERS; c++) begin
      for (int j = 0; j < WINDOW; j++) bucket_store[c][j] = '0;
      total_store[c] = '0;
    end
    active_count_shadow = '0;
    foreach (func_counts[k]) func_counts[k] = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset value of active_count, wrapping, rounding toward zero
    queue_txn(FUNC_READ,      0, '0);
    queue_txn(FUNC_COLLECT,   0, MAX_POS);
    queue_txn(FUNC_COLLECT,   0, MAX_POS);
    queue_txn(FUNC_TICK,      0, '0);
    queue_txn(FUNC_READ,      0, '0);
    queue_txn(FUNC_COLLECT, 255, MIN_NEG);
    queue_txn(FUNC_COLLECT, 255, -64'sd8);
    queue_txn(FUNC_READ,    255, '0);
    queue_txn(FUNC_CLEAR,   255, MAX_POS);
    queue_txn(FUNC_READ,    255, MIN_NEG);
    wait_for_drain(SETTLE_CYCLES);
    write_active_count(ACT_W'(2));

    // directed: ageing, bucket drop-out, inactive counter left alone, sum wrap
    queue_txn(FUNC_COLLECT, 2, 64'sd9);
    queue_txn(FUNC_COLLECT, 1, -64'sd7);
    queue_txn(FUNC_TICK,    0, '0);
    queue_txn(FUNC_COLLECT, 1, MAX_POS);
    queue_txn(FUNC_TICK,    0, '0);
    queue_txn(FUNC_COLLECT, 1, MAX_POS);
    queue_txn(FUNC_READ,    1, '0);
    queue_txn(FUNC_TICK,    0, '0);
    queue_txn(FUNC_TICK,    0, '0);
    queue_txn(FUNC_TICK,    0, '0);
    queue_txn(FUNC_READ,    1, '0);
    queue_txn(FUNC_READ,    2, '0);
    queue_txn(FUNC_CLEAR,   1, '0);
    queue_txn(FUNC_READ,    1, '0);
    wait_for_drain(SETTLE_CYCLES);

    // random phases, each with its own active_count and traffic pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active_count(ACT_W'(phase_cfg[p]));
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      repeat (RAND_PER_PHASE / 2) pending_txns.push_back(random_txn());
      // sender holds off until every outstanding read has returned
      wait_for_drain(0);
      repeat (RAND_PER_PHASE - RAND_PER_PHASE / 2) pending_txns.push_back(random_txn());
      wait_for_drain(SETTLE_CYCLES);
    end

    $display("sent %0d collect, %0d tick, %0d read, %0d clear transactions; %0d reads checked",
             func_counts[FUNC_COLLECT], func_counts[FUNC_TICK], func_counts[FUNC_READ],
             func_counts[FUNC_CLEAR], reads_checked);
    $display("active_count runs: 0, 2, 256, 511, 0, 1, %0d, 255; %0d check failures",
             phase_cfg[4], check_failures);
    if (check_failures == 0 && expected_reads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/swrc_pkg.sv
design/swrc_ram.sv
design/swrc_div.sv
design/sliding_window_rate_counters.sv
design/swrc_checker.sv
sim/sliding_window_rate_counters_tb.sv
